FILE: sv/prn_pkg.sv
// prn_pkg: shared types and codes for the Paxos role node.
// Used by prn_front, prn_queue, prn_back and paxos_role_node.
// No dependencies.
package prn_pkg;

    // input opcodes
    localparam logic [2:0] OP_REQUEST  = 3'd0;
    localparam logic [2:0] OP_PREPARE  = 3'd1;
    localparam logic [2:0] OP_PROMISE  = 3'd2;
    localparam logic [2:0] OP_ACCEPT   = 3'd3;
    localparam logic [2:0] OP_ACCEPTED = 3'd4;

    // node roles
    localparam logic [1:0] ROLE_PROPOSER = 2'd0;
    localparam logic [1:0] ROLE_ACCEPTOR = 2'd1;
    localparam logic [1:0] ROLE_LEARNER  = 2'd2;

    // outgoing message kinds
    localparam logic [1:0] KIND_PREPARE  = 2'd0;
    localparam logic [1:0] KIND_PROMISE  = 2'd1;
    localparam logic [1:0] KIND_ACCEPT   = 2'd2;
    localparam logic [1:0] KIND_ACCEPTED = 2'd3;

    // destination groups
    localparam logic [1:0] GRP_PROPOSERS = 2'd0;
    localparam logic [1:0] GRP_ACCEPTORS = 2'd1;
    localparam logic [1:0] GRP_LEARNERS  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_NODE_ROLE = 2'd0;
    localparam logic [1:0] CFG_QUORUM    = 2'd1;

    localparam int unsigned CFG_INDEX_BITS = 2;
    localparam int unsigned ROLE_BITS      = 2;
    localparam int unsigned COUNT_BITS     = 8;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX     = '1;
    localparam logic [COUNT_BITS-1:0] QUORUM_RESET  = 8'd1;

    // job queue geometry
    localparam int unsigned Q_DEPTH    = 2;
    localparam int unsigned Q_PTR_BITS = 1;
    localparam int unsigned Q_CNT_BITS = 2;

    // control part of one queued job
    typedef struct packed {
        logic [1:0] kind;   // first outgoing message kind
        logic       dual;   // a second copy goes to the learners
    } job_ctrl_t;

endpackage

FILE: sv/prn_front.sv
// prn_front: accepts messages, holds role registers and node state,
// and turns each message into at most one job for the back end.
// Depends on prn_pkg.
module prn_front #(
    parameter int unsigned BALLOT_BITS = 32,
    parameter int unsigned VALUE_BITS  = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [2:0]                         opcode,
    input  logic [BALLOT_BITS-1:0]             ballot,
    input  logic [BALLOT_BITS-1:0]             prior_ballot,
    input  logic [VALUE_BITS-1:0]              payload,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [prn_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [prn_pkg::COUNT_BITS-1:0]     cfg_data,
    input  logic                               q_full,
    output logic                               q_push,
    output prn_pkg::job_ctrl_t                 q_ctrl,
    output logic [BALLOT_BITS-1:0]             q_ballot,
    output logic [BALLOT_BITS-1:0]             q_prior,
    output logic [VALUE_BITS-1:0]              q_value
);
    import prn_pkg::*;

    logic [ROLE_BITS-1:0]   role_reg;
    logic [COUNT_BITS-1:0]  quorum_reg;
    logic [BALLOT_BITS-1:0] cur_ballot_reg, cur_ballot_next;
    logic [BALLOT_BITS-1:0] high_ballot_reg, high_ballot_next;
    logic [VALUE_BITS-1:0]  held_value_reg, held_value_next;
    logic [COUNT_BITS-1:0]  count_reg, count_next;
    logic                   accept;
    logic [BALLOT_BITS-1:0] ballot_inc;

    assign in_ready   = !q_full;
    assign cfg_ready  = 1'b1;
    assign accept     = in_valid && in_ready;
    assign ballot_inc = cur_ballot_reg + {{(BALLOT_BITS-1){1'b0}}, 1'b1};

    always_comb
    begin
        cur_ballot_next  = cur_ballot_reg;
        high_ballot_next = high_ballot_reg;
        held_value_next  = held_value_reg;
        count_next       = count_reg;
        q_push           = 1'b0;
        q_ctrl           = '{kind: KIND_PREPARE, dual: 1'b0};
        q_ballot         = '0;
        q_prior          = '0;
        q_value          = '0;
        unique case (role_reg)
            ROLE_PROPOSER:
            begin
                if (opcode == OP_REQUEST)
                begin
                    cur_ballot_next = ballot_inc;
                    count_next      = '0;
                    held_value_next = payload;
                    q_push          = 1'b1;
                    q_ctrl.kind     = KIND_PREPARE;
                    q_ballot        = ballot_inc;
                end
                else if (opcode == OP_PROMISE && ballot == cur_ballot_reg)
                begin
                    if (high_ballot_reg < prior_ballot)
                    begin
                        high_ballot_next = prior_ballot;
                        held_value_next  = payload;
                    end
                    if (count_reg != COUNT_MAX)
                        count_next = count_reg + {{(COUNT_BITS-1){1'b0}}, 1'b1};
                    if (count_reg == quorum_reg)
                    begin
                        q_push      = 1'b1;
                        q_ctrl.kind = KIND_ACCEPT;
                        q_ballot    = cur_ballot_reg;
                        q_value     = held_value_reg;
                    end
                end
            end
            ROLE_ACCEPTOR:
            begin
                if (opcode == OP_PREPARE && cur_ballot_reg < ballot)
                begin
                    cur_ballot_next = ballot;
                    q_push          = 1'b1;
                    q_ctrl.kind     = KIND_PROMISE;
                    q_ballot        = ballot;
                    q_prior         = high_ballot_reg;
                    q_value         = held_value_reg;
                end
                else if (opcode == OP_ACCEPT && cur_ballot_reg <= ballot)
                begin
                    high_ballot_next = ballot;
                    held_value_next  = payload;
                    q_push           = 1'b1;
                    q_ctrl.kind      = KIND_ACCEPTED;
                    q_ctrl.dual      = 1'b1;
                    q_ballot         = ballot;
                    q_value          = payload;
                end
            end
            ROLE_LEARNER:
            begin
                if (opcode == OP_ACCEPTED)
                    held_value_next = payload;
            end
            default:
            begin
            end
        endcase
        if (!accept)
            q_push = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            role_reg        <= ROLE_PROPOSER;
            quorum_reg      <= QUORUM_RESET;
            cur_ballot_reg  <= '0;
            high_ballot_reg <= '0;
            held_value_reg  <= '0;
            count_reg       <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_NODE_ROLE)
                    role_reg <= cfg_data[ROLE_BITS-1:0];
                else if (cfg_index == CFG_QUORUM)
                    quorum_reg <= cfg_data;
            end
            if (accept)
            begin
                cur_ballot_reg  <= cur_ballot_next;
                high_ballot_reg <= high_ballot_next;
                held_value_reg  <= held_value_next;
                count_reg       <= count_next;
            end
        end
    end

endmodule

FILE: sv/prn_queue.sv
// prn_queue: two-entry job queue between front and back end.
// Depends on prn_pkg.
module prn_queue #(
    parameter int unsigned BALLOT_BITS = 32,
    parameter int unsigned VALUE_BITS  = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  prn_pkg::job_ctrl_t     push_ctrl,
    input  logic [BALLOT_BITS-1:0] push_ballot,
    input  logic [BALLOT_BITS-1:0] push_prior,
    input  logic [VALUE_BITS-1:0]  push_value,
    output logic                   full,
    output logic                   empty,
    input  logic                   pop,
    output prn_pkg::job_ctrl_t     head_ctrl,
    output logic [BALLOT_BITS-1:0] head_ballot,
    output logic [BALLOT_BITS-1:0] head_prior,
    output logic [VALUE_BITS-1:0]  head_value
);
    import prn_pkg::*;

    job_ctrl_t              ctrl_mem   [Q_DEPTH];
    logic [BALLOT_BITS-1:0] ballot_mem [Q_DEPTH];
    logic [BALLOT_BITS-1:0] prior_mem  [Q_DEPTH];
    logic [VALUE_BITS-1:0]  value_mem  [Q_DEPTH];
    logic [Q_PTR_BITS-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [Q_CNT_BITS-1:0]  count_reg;
    logic                   do_push, do_pop;

    assign full    = (count_reg == Q_CNT_BITS'(Q_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    assign head_ctrl   = ctrl_mem[rd_ptr_reg];
    assign head_ballot = ballot_mem[rd_ptr_reg];
    assign head_prior  = prior_mem[rd_ptr_reg];
    assign head_value  = value_mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            ctrl_mem[wr_ptr_reg]   <= push_ctrl;
            ballot_mem[wr_ptr_reg] <= push_ballot;
            prior_mem[wr_ptr_reg]  <= push_prior;
            value_mem[wr_ptr_reg]  <= push_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + Q_PTR_BITS'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + Q_PTR_BITS'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + Q_CNT_BITS'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - Q_CNT_BITS'(1);
        end
    end

endmodule

FILE: sv/prn_back.sv
// prn_back: drains jobs and drives the registered output channel,
// splitting an accepted job into its proposer and learner copies.
// Depends on prn_pkg.
module prn_back #(
    parameter int unsigned BALLOT_BITS = 32,
    parameter int unsigned VALUE_BITS  = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_empty,
    output logic                   q_pop,
    input  prn_pkg::job_ctrl_t     q_ctrl,
    input  logic [BALLOT_BITS-1:0] q_ballot,
    input  logic [BALLOT_BITS-1:0] q_prior,
    input  logic [VALUE_BITS-1:0]  q_value,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [1:0]             out_kind,
    output logic [1:0]             dest_group,
    output logic [BALLOT_BITS-1:0] out_ballot,
    output logic [BALLOT_BITS-1:0] out_prior_ballot,
    output logic [VALUE_BITS-1:0]  out_value,
    output logic                   last
);
    import prn_pkg::*;

    logic                   valid_reg, valid_next;
    logic                   pending_reg, pending_next;
    logic [1:0]             kind_reg;
    logic [1:0]             grp_reg, grp_next;
    logic [BALLOT_BITS-1:0] ballot_reg;
    logic [BALLOT_BITS-1:0] prior_reg;
    logic [VALUE_BITS-1:0]  value_reg;
    logic                   last_reg, last_next;
    logic                   slot_free;
    logic                   load_second;

    assign slot_free   = !valid_reg || out_ready;
    assign load_second = slot_free && pending_reg;
    assign q_pop       = slot_free && !pending_reg && !q_empty;

    always_comb
    begin
        unique case (q_ctrl.kind)
            KIND_PREPARE:  grp_next = GRP_ACCEPTORS;
            KIND_PROMISE:  grp_next = GRP_PROPOSERS;
            KIND_ACCEPT:   grp_next = GRP_ACCEPTORS;
            KIND_ACCEPTED: grp_next = GRP_PROPOSERS;
            default:       grp_next = GRP_PROPOSERS;
        endcase
        last_next = !q_ctrl.dual;
    end

    always_comb
    begin
        valid_next   = valid_reg;
        pending_next = pending_reg;
        priority if (load_second)
        begin
            valid_next   = 1'b1;
            pending_next = 1'b0;
        end
        else if (q_pop)
        begin
            valid_next   = 1'b1;
            pending_next = q_ctrl.dual;
        end
        else if (slot_free)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= 1'b0;
            pending_reg <= 1'b0;
        end
        else
        begin
            valid_reg   <= valid_next;
            pending_reg <= pending_next;
        end
    end

    // second copy of an accepted keeps ballot and value, retargets learners
    always_ff @(posedge clk)
    begin
        if (load_second)
        begin
            grp_reg  <= GRP_LEARNERS;
            last_reg <= 1'b1;
        end
        else if (q_pop)
        begin
            kind_reg   <= q_ctrl.kind;
            grp_reg    <= grp_next;
            ballot_reg <= q_ballot;
            prior_reg  <= q_prior;
            value_reg  <= q_value;
            last_reg   <= last_next;
        end
    end

    assign out_valid        = valid_reg;
    assign out_kind         = kind_reg;
    assign dest_group       = grp_reg;
    assign out_ballot       = ballot_reg;
    assign out_prior_ballot = prior_reg;
    assign out_value        = value_reg;
    assign last             = last_reg;

endmodule

FILE: sv/paxos_role_node.sv
// paxos_role_node: top level of the single-decree Paxos role node.
// Instantiates prn_front, prn_queue and prn_back; uses prn_pkg.
//
//   channel | signals                                        | dir
//   --------+------------------------------------------------+-----
//   in      | in_valid/in_ready, opcode, ballot, prior_ballot,| in
//           | payload                                        |
//   out     | out_valid/out_ready, out_kind, dest_group,     | out
//           | out_ballot, out_prior_ballot, out_value, last  |
//   cfg     | cfg_valid/cfg_ready, cfg_index, cfg_data       | in
//
// One message is taken per cycle while the job queue is not full; state
// updates at acceptance in the front. Each message yields 0, 1 or 2
// outputs, one per cycle from the back end's output register while
// out_ready is high. A two-entry job queue separates the halves; the input
// stalls only when it is full. cfg_ready is always high. Reset is async.
module paxos_role_node #(
    parameter int unsigned BALLOT_BITS = 32,
    parameter int unsigned VALUE_BITS  = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [2:0]                         opcode,
    input  logic [BALLOT_BITS-1:0]             ballot,
    input  logic [BALLOT_BITS-1:0]             prior_ballot,
    input  logic [VALUE_BITS-1:0]              payload,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [1:0]                         out_kind,
    output logic [1:0]                         dest_group,
    output logic [BALLOT_BITS-1:0]             out_ballot,
    output logic [BALLOT_BITS-1:0]             out_prior_ballot,
    output logic [VALUE_BITS-1:0]              out_value,
    output logic                               last,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [prn_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [prn_pkg::COUNT_BITS-1:0]     cfg_data
);
    import prn_pkg::*;

    logic                   q_full, q_empty, q_push, q_pop;
    job_ctrl_t              push_ctrl, head_ctrl;
    logic [BALLOT_BITS-1:0] push_ballot, push_prior, head_ballot, head_prior;
    logic [VALUE_BITS-1:0]  push_value, head_value;

    prn_front #(
        .BALLOT_BITS (BALLOT_BITS),
        .VALUE_BITS  (VALUE_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .opcode       (opcode),
        .ballot       (ballot),
        .prior_ballot (prior_ballot),
        .payload      (payload),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_ctrl       (push_ctrl),
        .q_ballot     (push_ballot),
        .q_prior      (push_prior),
        .q_value      (push_value)
    );

    prn_queue #(
        .BALLOT_BITS (BALLOT_BITS),
        .VALUE_BITS  (VALUE_BITS)
    ) u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (q_push),
        .push_ctrl   (push_ctrl),
        .push_ballot (push_ballot),
        .push_prior  (push_prior),
        .push_value  (push_value),
        .full        (q_full),
        .empty       (q_empty),
        .pop         (q_pop),
        .head_ctrl   (head_ctrl),
        .head_ballot (head_ballot),
        .head_prior  (head_prior),
        .head_value  (head_value)
    );

    prn_back #(
        .BALLOT_BITS (BALLOT_BITS),
        .VALUE_BITS  (VALUE_BITS)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .q_empty          (q_empty),
        .q_pop            (q_pop),
        .q_ctrl           (head_ctrl),
        .q_ballot         (head_ballot),
        .q_prior          (head_prior),
        .q_value          (head_value),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .out_kind         (out_kind),
        .dest_group       (dest_group),
        .out_ballot       (out_ballot),
        .out_prior_ballot (out_prior_ballot),
        .out_value        (out_value),
        .last             (last)
    );

endmodule
